[rtl/core/polynomial_root_finder_top_macros.svh]
// ---------------------------------------------------------------------------
// Polynomial root finder assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_ROOT_FINDER_TOP_MACROS_SVH
`define POLYNOMIAL_ROOT_FINDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/prf_pkg.sv]
// ---------------------------------------------------------------------------
// Polynomial root finder package
// Shared widths, state codes, the sign-magnitude adder and 32-bit saturation.
// ---------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

   localparam int LIMB_W      = 32;
   localparam int LIMBS       = 4;
   localparam int LIMB_IW     = 2;
   localparam int MAG_W       = 128;
   localparam int PROD_W      = 160;
   localparam int NUM_W       = 160;
   localparam int QUO_W       = 41;
   localparam int XW          = 48;
   localparam int SEED_SLOTS  = 7;
   localparam int SEED_IW     = 3;
   localparam int GRID_POINTS = 400;
   localparam int GRID_W      = 9;
   localparam int DIV_CW      = 8;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_ADD    = 8'b0000_0100,
      ST_POST   = 8'b0000_1000,
      ST_LOAD   = 8'b0001_0000,
      ST_NEWTON = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      PH_SCAN = 3'b001,
      PH_FX   = 3'b010,
      PH_FXH  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [MAG_W-1:0] m;
      logic             neg;
   } sm_type;

   function automatic sm_type sm_add(input sm_type a, input sm_type b);
      logic [MAG_W:0] sum;
      logic [MAG_W:0] dab;
      logic [MAG_W:0] dba;
      sm_type         r;
      sum = {1'b0, a.m} + {1'b0, b.m};
      dab = {1'b0, a.m} - {1'b0, b.m};
      dba = {1'b0, b.m} - {1'b0, a.m};
      if (a.neg == b.neg) begin
         r.m   = sum[MAG_W] ? '1 : sum[MAG_W-1:0];
         r.neg = a.neg;
      end else if (!dab[MAG_W]) begin
         r.m   = dab[MAG_W-1:0];
         r.neg = a.neg;
      end else begin
         r.m   = dba[MAG_W-1:0];
         r.neg = b.neg;
      end
      if (r.m == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
      logic fits;
      fits = (&v[XW-1:31]) | ~(|v[XW-1:31]);
      if (fits) begin
         return v[31:0];
      end else if (v[XW-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/prf_divider.sv]
// ---------------------------------------------------------------------------
// Polynomial root finder divider
// Restoring divider, one quotient bit per cycle, quotient capped at 2^40.
// ---------------------------------------------------------------------------
`default_nettype none

module prf_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [prf_pkg::NUM_W-1:0]  numerator,
   input  wire logic [prf_pkg::MAG_W-1:0]  denominator,
   output logic                            done,
   output logic [prf_pkg::QUO_W-1:0]       quotient
);
   import prf_pkg::*;

   localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << (QUO_W - 1);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [MAG_W-1:0]    den_ff, den_in;
   logic [MAG_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [MAG_W:0]      rem_sh;
   logic [MAG_W:0]      rem_sub;
   logic                ge;
   logic [QUO_W-1:0]    quo_t;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      quo_t   = (quo_ff < QCAP) ? {quo_ff[QUO_W-2:0], ge} : quo_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_CW'(NUM_W - 1);
         num_in = numerator;
         den_in = denominator;
         rem_in = '0;
         quo_in = '0;
      end else if (run_ff) begin
         num_in = num_ff << 1;
         rem_in = ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
         quo_in = (quo_t > QCAP) ? QCAP : quo_t;
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/polynomial_root_finder_top.sv]
// ---------------------------------------------------------------------------
// Polynomial root finder
// Sign-change scan over [-100, 100) followed by Newton refinement per seed.
// ---------------------------------------------------------------------------
// Terms arrive on the request channel, one beat per cycle while busy is low:
// a beat is taken when start is high and busy is low. A term whose power is
// out of range, or which arrives when the store is full, is dropped and
// flagged on every result of that run. The beat carrying last_term starts the
// search and raises busy until the final result has been issued.
// Each polynomial evaluation runs Horner's rule on one shared 32x32
// multiplier and one 128-bit sign-magnitude adder, with a MUL state per
// limb and an ADD state per power, then a closing POST state. The scan
// costs 400 evaluations. Each Newton step then costs two evaluations plus
// a restoring division, with up to newton_steps steps per seed and up to
// seven seeds.
// Results appear one beat at a time on the response ports, marked by
// rsp_strobe for a single cycle; the receiver cannot stall them. busy falls
// in the same cycle as the strobe of the final result of the run.
// The Newton step count is written through the csr channel while idle; it
// resets to five. Reset clears the term sums, term count, drop flag and strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module polynomial_root_finder_top #(
   parameter int MAX_TERMS = 8,
   parameter int MAX_POWER = 7,
   parameter int FRAC_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_coefficient,
   input  wire logic [2:0]         req_power,
   input  wire logic               req_last_term,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_root,
   output logic                    rsp_root_valid,
   output logic                    rsp_terms_dropped,
   output logic                    rsp_last_root,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [3:0]         csr_newton_steps
);
   import prf_pkg::*;

   `include "polynomial_root_finder_top_macros.svh"

   localparam int PW    = (MAX_POWER > 1) ? $clog2(MAX_POWER + 1) : 1;
   localparam int CW    = $clog2(MAX_TERMS + 1);
   localparam int SUM_W = 17 + $clog2(MAX_TERMS + 1);

   localparam logic signed [XW-1:0] GRID_START = -(XW'(100) << FRAC_BITS);
   localparam logic signed [XW-1:0] HALF       = XW'(1) << (FRAC_BITS - 1);
   localparam logic signed [XW-1:0] HSTEP      = XW'(1) << (FRAC_BITS - 10);
   localparam logic [MAG_W-1:0]     BOUND      = (FRAC_BITS >= 21) ?
      (MAG_W'(1) << ((FRAC_BITS >= 21) ? (FRAC_BITS - 21) : 0)) : '0;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [3:0]               steps_ff, steps_in;
   logic [CW-1:0]            tcount_ff, tcount_in;
   logic                     ovf_ff, ovf_in;
   logic signed [SUM_W-1:0]  sums_ff [0:MAX_POWER];
   sm_type                   acc_ff, acc_in;
   sm_type                   fx_ff, fx_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [31:0]       xev_ff, xev_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [XW-1:0]     gx_ff, gx_in;
   logic [GRID_W-1:0]        k_ff, k_in;
   logic [SEED_IW-1:0]       nseeds_ff, nseeds_in;
   logic                     plus_ff, plus_in;
   logic [SEED_IW-1:0]       s_ff, s_in;
   logic [3:0]               t_ff, t_in;
   logic [PW-1:0]            p_ff, p_in;
   logic [LIMB_IW-1:0]       limb_ff, limb_in;
   logic                     qneg_ff, qneg_in;
   logic signed [31:0]       seed_ff [0:SEED_SLOTS-1];
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic signed [31:0]       rsp_root_ff, rsp_root_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_drop_ff, rsp_drop_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     sum_we, sums_clr, seed_we;
   logic [PW-1:0]            sum_idx;
   logic signed [SUM_W-1:0]  sum_wd;
   logic signed [31:0]       seed_wd;
   logic                     term_ok;
   logic [LIMB_W-1:0]        xm;
   logic [2*LIMB_W-1:0]      pp;
   logic [PROD_W-1:0]        shr;
   sm_type                   mx, tm, add_a, add_b, add_r;
   logic signed [SUM_W-1:0]  sv;
   logic [SUM_W-1:0]         sabs;
   logic                     vpos, flip, last_emit;
   logic signed [XW-1:0]     xw;
   logic                     div_start, div_done;
   logic [NUM_W-1:0]         div_num;
   logic [QUO_W-1:0]         div_q;

   prf_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (add_r.m),
      .done        (div_done),
      .quotient    (div_q)
   );

   always_comb begin
      xm    = xev_ff[31] ? LIMB_W'(-xev_ff) : LIMB_W'(xev_ff);
      pp    = acc_ff.m[limb_ff*LIMB_W +: LIMB_W] * xm;
      shr   = prod_ff >> FRAC_BITS;
      mx.m  = (|shr[PROD_W-1:MAG_W]) ? '1 : shr[MAG_W-1:0];
      mx.neg = (acc_ff.neg ^ xev_ff[31]) & (|mx.m);
      sv    = sums_ff[p_ff];
      sabs  = sv[SUM_W-1] ? SUM_W'(-sv) : SUM_W'(sv);
      tm.m  = MAG_W'(sabs) << FRAC_BITS;
      tm.neg = sv[SUM_W-1];
      if (state_ff == ST_ADD) begin
         add_a = mx;
         add_b = tm;
      end else begin
         add_a     = acc_ff;
         add_b.m   = fx_ff.m;
         add_b.neg = ~fx_ff.neg & (|fx_ff.m);
      end
      add_r   = sm_add(add_a, add_b);
      div_num = NUM_W'(fx_ff.m) << (FRAC_BITS - 10);
      xw      = {{(XW-32){x_ff[31]}}, x_ff};
      vpos    = ~acc_ff.neg & (|acc_ff.m);
      flip    = (acc_ff.neg & plus_ff) | (vpos & ~plus_ff);
      term_ok = (32'(req_power) <= 32'(MAX_POWER)) && (32'(tcount_ff) < 32'(MAX_TERMS));
      sum_idx = PW'(req_power);
      sum_wd  = sums_ff[sum_idx] + SUM_W'(req_coefficient);
      last_emit = (nseeds_ff == '0) || ((s_ff + SEED_IW'(1)) == nseeds_ff);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      steps_in      = steps_ff;
      tcount_in     = tcount_ff;
      ovf_in        = ovf_ff;
      acc_in        = acc_ff;
      fx_in         = fx_ff;
      prod_in       = prod_ff;
      xev_in        = xev_ff;
      x_in          = x_ff;
      gx_in         = gx_ff;
      k_in          = k_ff;
      nseeds_in     = nseeds_ff;
      plus_in       = plus_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      p_in          = p_ff;
      limb_in       = limb_ff;
      qneg_in       = qneg_ff;
      rsp_strobe_in = 1'b0;
      rsp_root_in   = rsp_root_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;
      sum_we        = 1'b0;
      sums_clr      = 1'b0;
      seed_we       = 1'b0;
      seed_wd       = sat32(gx_ff - HALF);
      div_start     = 1'b0;
      if (csr_valid && csr_ready) begin
         steps_in = csr_newton_steps;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (term_ok) begin
                  sum_we    = 1'b1;
                  tcount_in = tcount_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_term) begin
                  gx_in     = GRID_START;
                  k_in      = '0;
                  nseeds_in = '0;
                  phase_in  = PH_SCAN;
                  acc_in    = '0;
                  p_in      = PW'(MAX_POWER);
                  limb_in   = LIMB_IW'(LIMBS - 1);
                  xev_in    = sat32(GRID_START);
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = ((limb_ff == LIMB_IW'(LIMBS - 1)) ? '0 : (prod_ff << LIMB_W))
                      + PROD_W'(pp);
            if (limb_ff == '0) begin
               state_in = ST_ADD;
            end else begin
               limb_in = limb_ff - LIMB_IW'(1);
            end
         end
         ST_ADD: begin
            acc_in = add_r;
            if (p_ff == '0) begin
               state_in = ST_POST;
            end else begin
               p_in     = p_ff - PW'(1);
               limb_in  = LIMB_IW'(LIMBS - 1);
               state_in = ST_MUL;
            end
         end
         ST_POST: begin
            unique case (phase_ff)
               PH_SCAN: begin
                  if (k_ff == '0) begin
                     plus_in = vpos;
                  end else if (flip) begin
                     plus_in = vpos;
                     if (32'(nseeds_ff) < SEED_SLOTS) begin
                        seed_we   = 1'b1;
                        nseeds_in = nseeds_ff + SEED_IW'(1);
                     end
                  end
                  if (k_ff == GRID_W'(GRID_POINTS - 1)) begin
                     s_in     = '0;
                     state_in = (nseeds_in == '0) ? ST_EMIT : ST_LOAD;
                  end else begin
                     k_in     = k_ff + GRID_W'(1);
                     gx_in    = gx_ff + HALF;
                     acc_in   = '0;
                     p_in     = PW'(MAX_POWER);
                     limb_in  = LIMB_IW'(LIMBS - 1);
                     xev_in   = sat32(gx_ff + HALF);
                     state_in = ST_MUL;
                  end
               end
               PH_FX: begin
                  fx_in    = acc_ff;
                  phase_in = PH_FXH;
                  acc_in   = '0;
                  p_in     = PW'(MAX_POWER);
                  limb_in  = LIMB_IW'(LIMBS - 1);
                  xev_in   = sat32(xw + HSTEP);
                  state_in = ST_MUL;
               end
               PH_FXH: begin
                  if (add_r.m <= BOUND) begin
                     state_in = ST_EMIT;
                  end else begin
                     div_start = 1'b1;
                     qneg_in   = fx_ff.neg ^ add_r.neg;
                     state_in  = ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_LOAD: begin
            x_in     = seed_ff[s_ff];
            t_in     = '0;
            state_in = ST_NEWTON;
         end
         ST_NEWTON: begin
            if (t_ff == steps_ff) begin
               state_in = ST_EMIT;
            end else begin
               phase_in = PH_FX;
               acc_in   = '0;
               p_in     = PW'(MAX_POWER);
               limb_in  = LIMB_IW'(LIMBS - 1);
               xev_in   = x_ff;
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               x_in     = qneg_ff ? sat32(xw + XW'(div_q)) : sat32(xw - XW'(div_q));
               t_in     = t_ff + 4'd1;
               state_in = ST_NEWTON;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_root_in   = (nseeds_ff == '0) ? '0 : x_ff;
            rsp_valid_in  = (nseeds_ff != '0);
            rsp_drop_in   = ovf_ff;
            rsp_last_in   = last_emit;
            if (last_emit) begin
               sums_clr  = 1'b1;
               tcount_in = '0;
               ovf_in    = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               s_in     = s_ff + SEED_IW'(1);
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SCAN;
         steps_ff      <= 4'd5;
         tcount_ff     <= '0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i <= MAX_POWER; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         steps_ff      <= steps_in;
         tcount_ff     <= tcount_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (sums_clr) begin
            for (int i = 0; i <= MAX_POWER; i++) begin
               sums_ff[i] <= '0;
            end
         end else if (sum_we) begin
            sums_ff[sum_idx] <= sum_wd;
         end
      end
      acc_ff       <= acc_in;
      fx_ff        <= fx_in;
      prod_ff      <= prod_in;
      xev_ff       <= xev_in;
      x_ff         <= x_in;
      gx_ff        <= gx_in;
      k_ff         <= k_in;
      nseeds_ff    <= nseeds_in;
      plus_ff      <= plus_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      limb_ff      <= limb_in;
      qneg_ff      <= qneg_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_last_ff  <= rsp_last_in;
      if (seed_we) begin
         seed_ff[nseeds_ff] <= seed_wd;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_root          = rsp_root_ff;
   assign rsp_root_valid    = rsp_valid_ff;
   assign rsp_terms_dropped = rsp_drop_ff;
   assign rsp_last_root     = rsp_last_ff;

   `PRF_ASSERT_NEXT(a_emit_strobe, state_ff == ST_EMIT, rsp_strobe, "emit without a result beat")
   `PRF_ASSERT_SAME(a_last_frees, rsp_strobe, busy == !rsp_last_root, "busy out of step with run end")
   `PRF_ASSERT_SAME(a_noroot_last, rsp_strobe && !rsp_root_valid, rsp_last_root, "rootless beat not last")

endmodule

`default_nettype wire
